// ===== hw/rtl/dfs_cc_pkg.sv =====
// ----------------------------------------------------------------------------
// DFS connected components package
// Shared state, command and event codes for the traversal engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_cc_pkg;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_STEP   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    EV_NEW   = 2'd0,
    EV_ENTER = 2'd1,
    EV_EXIT  = 2'd2,
    EV_DONE  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WALK,
    PH_ROOT
  } phase_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_E_RD,
    ST_E_W1,
    ST_E_W2,
    ST_V_CLR,
    ST_DISP,
    ST_SCAN,
    ST_TOP,
    ST_CUR,
    ST_NBR,
    ST_VIS,
    ST_PUSH
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dfs_cc_ram.sv =====
// ----------------------------------------------------------------------------
// DFS connected components RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_cc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dfs_connected_components.sv =====
// ----------------------------------------------------------------------------
// DFS connected components
// Undirected graph store with a depth-first walk that reports one event per
// step command.
//
//   channel   signals                                   flow control
//   command   start, busy, in_func, in_end_a, in_end_b  start while busy low
//   event     out_valid, out_event_kind, out_event_node one-cycle strobe
//   config    cfg_valid, cfg_ready, cfg_data            valid and ready
//
// A step skips each visited neighbor and each visited node passed in the
// root scan; the first step of a walk also wipes the visited map.
// After reset the block is busy while it empties the lists.
// Events cannot be stalled; the configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_connected_components
  import dfs_cc_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [10:0] in_end_a,
  input  wire logic [10:0] in_end_b,
  output logic             out_valid,
  output logic [1:0]       out_event_kind,
  output logic [10:0]      out_event_node,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);

  localparam int ENTRY_CAP = 2 * MAX_EDGES;
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int SW  = $clog2(MAX_NODES + 2);
  localparam int EW  = $clog2(ENTRY_CAP + 1);
  localparam int EAW = $clog2(ENTRY_CAP);
  localparam int SAW = $clog2(MAX_NODES);
  localparam int CW  = (SW > 11) ? SW : 11;
  localparam logic [EW-1:0] LINK_NONE = EW'(ENTRY_CAP);

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [NW-1:0]   nc_r, nc_nxt;
  logic [EW-1:0]   fill_r, fill_nxt;
  logic [NW-1:0]   depth_r, depth_nxt;
  logic [SW-1:0]   scan_r, scan_nxt;
  logic [NW-1:0]   clr_r, clr_nxt;
  logic [NW-1:0]   x_r, x_nxt;
  logic [NW-1:0]   y_r, y_nxt;
  logic            second_r, second_nxt;
  logic [EW-1:0]   tl_r, tl_nxt;
  logic [NW-1:0]   t_r, t_nxt;
  logic [EW-1:0]   c_r, c_nxt;
  logic [EW-1:0]   nl_r, nl_nxt;
  logic [NW-1:0]   v_r, v_nxt;
  logic            ov_r, ov_nxt;
  logic [1:0]      okind_r, okind_nxt;
  logic [NW-1:0]   onode_r, onode_nxt;

  logic            nbr_we;
  logic [EAW-1:0]  nbr_waddr, nbr_raddr;
  logic [NW-1:0]   nbr_wdata, nbr_rd;
  logic            link_we;
  logic [EAW-1:0]  link_waddr;
  logic [EW-1:0]   link_wdata, link_rd;
  logic            head_we;
  logic [NW-1:0]   head_waddr, head_raddr;
  logic [EW-1:0]   head_wdata, head_rd;
  logic            tail_we;
  logic [NW-1:0]   tail_waddr, tail_raddr;
  logic [EW-1:0]   tail_wdata, tail_rd;
  logic            vis_we;
  logic [NW-1:0]   vis_waddr, vis_raddr;
  logic            vis_wdata, vis_rd;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [NW+EW-1:0] stk_wdata, stk_rd;

  logic            edge_ok;
  logic [SW-1:0]   scan_inc;

  dfs_cc_ram #(.WIDTH(NW), .DEPTH(ENTRY_CAP)) u_nbr (
    .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
    .raddr(nbr_raddr), .rdata(nbr_rd));

  dfs_cc_ram #(.WIDTH(EW), .DEPTH(ENTRY_CAP)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(nbr_raddr), .rdata(link_rd));

  dfs_cc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 1)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd));

  dfs_cc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 1)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .raddr(tail_raddr), .rdata(tail_rd));

  dfs_cc_ram #(.WIDTH(1), .DEPTH(MAX_NODES + 1)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rd));

  dfs_cc_ram #(.WIDTH(NW + EW), .DEPTH(MAX_NODES)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd));

  assign busy           = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = ov_r;
  assign out_event_kind = okind_r;
  assign out_event_node = 11'(onode_r);

  assign edge_ok = (in_end_a != 11'd0) && (in_end_b != 11'd0) &&
                   (CW'(in_end_a) <= CW'(nc_r)) && (CW'(in_end_b) <= CW'(nc_r)) &&
                   ((EW + 1)'(fill_r) + (EW + 1)'(2) <= (EW + 1)'(ENTRY_CAP));
  assign scan_inc = scan_r + SW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      phase_r  <= PH_IDLE;
      nc_r     <= '0;
      fill_r   <= '0;
      depth_r  <= '0;
      scan_r   <= SW'(1);
      clr_r    <= '0;
      second_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      nc_r     <= nc_nxt;
      fill_r   <= fill_nxt;
      depth_r  <= depth_nxt;
      scan_r   <= scan_nxt;
      clr_r    <= clr_nxt;
      second_r <= second_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    tl_r    <= tl_nxt;
    t_r     <= t_nxt;
    c_r     <= c_nxt;
    nl_r    <= nl_nxt;
    v_r     <= v_nxt;
    okind_r <= okind_nxt;
    onode_r <= onode_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    nc_nxt     = nc_r;
    fill_nxt   = fill_r;
    depth_nxt  = depth_r;
    scan_nxt   = scan_r;
    clr_nxt    = clr_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    second_nxt = second_r;
    tl_nxt     = tl_r;
    t_nxt      = t_r;
    c_nxt      = c_r;
    nl_nxt     = nl_r;
    v_nxt      = v_r;
    ov_nxt     = 1'b0;
    okind_nxt  = okind_r;
    onode_nxt  = onode_r;

    nbr_we     = 1'b0;
    nbr_waddr  = fill_r[EAW-1:0];
    nbr_wdata  = y_r;
    nbr_raddr  = c_r[EAW-1:0];
    link_we    = 1'b0;
    link_waddr = fill_r[EAW-1:0];
    link_wdata = LINK_NONE;
    head_we    = 1'b0;
    head_waddr = x_r;
    head_wdata = fill_r;
    head_raddr = v_r;
    tail_we    = 1'b0;
    tail_waddr = x_r;
    tail_wdata = fill_r;
    tail_raddr = x_r;
    vis_we     = 1'b0;
    vis_waddr  = v_r;
    vis_wdata  = 1'b1;
    vis_raddr  = NW'(scan_r);
    stk_we     = 1'b0;
    stk_waddr  = SAW'(depth_r);
    stk_wdata  = {v_r, head_rd};
    stk_raddr  = SAW'(depth_r - NW'(1));

    if (cfg_valid) begin
      if (CW'(cfg_data) > CW'(MAX_NODES)) begin
        nc_nxt = NW'(MAX_NODES);
      end else begin
        nc_nxt = NW'(cfg_data);
      end
    end

    case (state_r)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        head_wdata = LINK_NONE;
        tail_we    = 1'b1;
        tail_waddr = clr_r;
        tail_wdata = LINK_NONE;
        clr_nxt    = clr_r + NW'(1);
        if (clr_r == NW'(MAX_NODES)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (in_func)
            FN_ADD: begin
              if (edge_ok) begin
                x_nxt      = NW'(in_end_a);
                y_nxt      = NW'(in_end_b);
                second_nxt = 1'b0;
                state_nxt  = ST_E_RD;
              end
            end
            FN_STEP: begin
              clr_nxt = '0;
              if (phase_r == PH_IDLE) begin
                state_nxt = ST_V_CLR;
              end else begin
                state_nxt = ST_DISP;
              end
            end
            FN_CLEAR: begin
              clr_nxt   = '0;
              fill_nxt  = '0;
              depth_nxt = '0;
              scan_nxt  = SW'(1);
              phase_nxt = PH_IDLE;
              state_nxt = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_E_RD: begin
        tail_raddr = x_r;
        state_nxt  = ST_E_W1;
      end
      ST_E_W1: begin
        tl_nxt  = tail_rd;
        nbr_we  = 1'b1;
        link_we = 1'b1;
        tail_we = 1'b1;
        head_we = (tail_rd == LINK_NONE);
        if (tail_rd != LINK_NONE) begin
          state_nxt = ST_E_W2;
        end else begin
          fill_nxt = fill_r + EW'(1);
          if (!second_r) begin
            x_nxt      = y_r;
            y_nxt      = x_r;
            second_nxt = 1'b1;
            state_nxt  = ST_E_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_E_W2: begin
        link_we    = 1'b1;
        link_waddr = tl_r[EAW-1:0];
        link_wdata = fill_r;
        fill_nxt   = fill_r + EW'(1);
        if (!second_r) begin
          x_nxt      = y_r;
          y_nxt      = x_r;
          second_nxt = 1'b1;
          state_nxt  = ST_E_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_V_CLR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_r;
        vis_wdata = 1'b0;
        clr_nxt   = clr_r + NW'(1);
        if (clr_r == NW'(MAX_NODES)) begin
          scan_nxt  = SW'(1);
          depth_nxt = '0;
          phase_nxt = PH_WALK;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        if (phase_r == PH_ROOT) begin
          head_raddr = NW'(scan_r);
          v_nxt      = NW'(scan_r);
          phase_nxt  = PH_WALK;
          state_nxt  = ST_PUSH;
        end else if (depth_r != '0) begin
          state_nxt = ST_TOP;
        end else if (CW'(scan_r) <= CW'(nc_r)) begin
          vis_raddr = NW'(scan_r);
          state_nxt = ST_SCAN;
        end else begin
          phase_nxt = PH_IDLE;
          ov_nxt    = 1'b1;
          okind_nxt = EV_DONE;
          onode_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (vis_rd) begin
          scan_nxt = scan_inc;
          if (CW'(scan_inc) <= CW'(nc_r)) begin
            vis_raddr = NW'(scan_inc);
          end else begin
            phase_nxt = PH_IDLE;
            ov_nxt    = 1'b1;
            okind_nxt = EV_DONE;
            onode_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end else begin
          phase_nxt = PH_ROOT;
          ov_nxt    = 1'b1;
          okind_nxt = EV_NEW;
          onode_nxt = NW'(scan_r);
          state_nxt = ST_IDLE;
        end
      end
      ST_TOP: begin
        t_nxt     = stk_rd[NW+EW-1:EW];
        c_nxt     = stk_rd[EW-1:0];
        state_nxt = ST_CUR;
      end
      ST_CUR: begin
        if (c_r == LINK_NONE) begin
          depth_nxt = depth_r - NW'(1);
          ov_nxt    = 1'b1;
          okind_nxt = EV_EXIT;
          onode_nxt = t_r;
          state_nxt = ST_IDLE;
        end else begin
          nbr_raddr = c_r[EAW-1:0];
          state_nxt = ST_NBR;
        end
      end
      ST_NBR: begin
        v_nxt     = nbr_rd;
        nl_nxt    = link_rd;
        vis_raddr = nbr_rd;
        state_nxt = ST_VIS;
      end
      ST_VIS: begin
        if (!vis_rd && (CW'(depth_r) < CW'(MAX_NODES))) begin
          stk_we     = 1'b1;
          stk_waddr  = SAW'(depth_r - NW'(1));
          stk_wdata  = {t_r, nl_r};
          head_raddr = v_r;
          state_nxt  = ST_PUSH;
        end else begin
          c_nxt     = nl_r;
          state_nxt = ST_CUR;
        end
      end
      ST_PUSH: begin
        stk_we    = 1'b1;
        stk_waddr = SAW'(depth_r);
        stk_wdata = {v_r, head_rd};
        vis_we    = 1'b1;
        vis_waddr = v_r;
        vis_wdata = 1'b1;
        depth_nxt = depth_r + NW'(1);
        ov_nxt    = 1'b1;
        okind_nxt = EV_ENTER;
        onode_nxt = v_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_event_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (state_r == ST_IDLE))
    else $error("event strobe outside idle state");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(depth_r) <= CW'(MAX_NODES))
    else $error("stack depth above capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (EW + 1)'(fill_r) <= (EW + 1)'(ENTRY_CAP))
    else $error("entry fill above capacity");

  a_done_node: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (okind_r == EV_DONE)) |-> (onode_r == '0))
    else $error("walk done event carries a node");

  a_root_after_new: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (okind_r == EV_NEW)) |-> ((phase_r == PH_ROOT) && (depth_r == '0)))
    else $error("new component event without root phase");

endmodule

`default_nettype wire
